/* rtl/core/lcc_pkg.sv */
`default_nettype none
package lcc_pkg;

  localparam int LANES            = 4;
  localparam int NUM_FEATURES_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int FEAT_W           = 16;
  localparam int PROD_W           = 32;
  localparam int SCORE_W          = 35;
  localparam int Q_W              = 16;
  localparam int QDEPTH           = 2;
  localparam int CFG_AW           = 5;
  localparam int CFG_DW           = 32;
  localparam int IDX_W            = 3;

  localparam logic [IDX_W-1:0] REG_WEIGHT_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_WEIGHT_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_WEIGHT_C = 3'd2;
  localparam logic [IDX_W-1:0] REG_WEIGHT_D = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIAS     = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESH   = 3'd5;

  typedef struct packed {
    logic [LANES-1:0][FEAT_W-1:0] weight;
    logic [CFG_DW-1:0]            bias;
    logic [CFG_DW-1:0]            thresh;
  } cfg_t;

  typedef struct packed {
    logic pred;
    logic label;
    logic last;
  } verdict_t;

endpackage
`default_nettype wire

/* rtl/core/lcc_if.sv */
`default_nettype none
interface lcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature_a;
  logic signed [15:0] feature_b;
  logic signed [15:0] feature_c;
  logic signed [15:0] feature_d;
  logic               true_label;
  logic               last_sample;

  modport source (output valid, feature_a, feature_b, feature_c, feature_d,
                  true_label, last_sample, input ready);
  modport sink   (input valid, feature_a, feature_b, feature_c, feature_d,
                  true_label, last_sample, output ready);
endinterface

interface lcc_out_if;
  logic        valid;
  logic        ready;
  logic        predicted;
  logic        matches_label;
  logic [15:0] true_pos;
  logic [15:0] false_pos;
  logic [15:0] true_neg;
  logic [15:0] false_neg;
  logic [15:0] precision_q;
  logic [15:0] recall_q;
  logic [15:0] f1_q;
  logic        summary_valid;

  modport source (output valid, predicted, matches_label, true_pos, false_pos,
                  true_neg, false_neg, precision_q, recall_q, f1_q,
                  summary_valid, input ready);
  modport sink   (input valid, predicted, matches_label, true_pos, false_pos,
                  true_neg, false_neg, precision_q, recall_q, f1_q,
                  summary_valid, output ready);
endinterface
`default_nettype wire

/* rtl/core/lcc_front.sv */
`default_nettype none
module lcc_front #(
  parameter int NUM_FEATURES = lcc_pkg::NUM_FEATURES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lcc_in_if.sink                in_bus,
  input  wire lcc_pkg::cfg_t    cfg,
  output lcc_pkg::verdict_t     push_data,
  output logic                  push,
  input  wire logic             q_ready
);

  logic signed [lcc_pkg::PROD_W-1:0] prod_r   [lcc_pkg::LANES];
  logic signed [lcc_pkg::PROD_W-1:0] prod_nxt [lcc_pkg::LANES];
  logic [lcc_pkg::LANES-1:0][lcc_pkg::FEAT_W-1:0] feat;
  logic s1_valid_r, s1_valid_nxt;
  logic label_r, last_r;
  logic in_fire;
  logic signed [lcc_pkg::SCORE_W-1:0] score;
  logic signed [lcc_pkg::SCORE_W-1:0] thresh;

  assign feat[0] = in_bus.feature_a;
  assign feat[1] = in_bus.feature_b;
  assign feat[2] = in_bus.feature_c;
  assign feat[3] = in_bus.feature_d;

  assign in_bus.ready = !s1_valid_r || q_ready;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign push         = s1_valid_r && q_ready;

  always_comb begin
    logic signed [lcc_pkg::FEAT_W-1:0] f;
    logic signed [lcc_pkg::FEAT_W-1:0] w;
    for (int i = 0; i < lcc_pkg::LANES; i++) begin
      f = $signed(feat[i]);
      w = $signed(cfg.weight[i]);
      if (i < NUM_FEATURES) begin
        prod_nxt[i] = f * w;
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < lcc_pkg::LANES; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      label_r <= in_bus.true_label;
      last_r  <= in_bus.last_sample;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // exact score: bias plus lane products, compared as signed
  always_comb begin
    score = lcc_pkg::SCORE_W'($signed(cfg.bias));
    for (int i = 0; i < lcc_pkg::LANES; i++) begin
      score = score + lcc_pkg::SCORE_W'(prod_r[i]);
    end
    thresh = lcc_pkg::SCORE_W'($signed(cfg.thresh));
  end

  assign push_data.pred  = (score >= thresh);
  assign push_data.label = label_r;
  assign push_data.last  = last_r;

endmodule
`default_nettype wire

/* rtl/core/lcc_fifo.sv */
`default_nettype none
module lcc_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lcc_pkg::verdict_t push_data,
  output logic                   push_ready,
  input  wire logic              pop,
  output lcc_pkg::verdict_t      pop_data,
  output logic                   pop_valid
);

  localparam int AW = $clog2(lcc_pkg::QDEPTH);
  localparam int CW = AW + 1;

  lcc_pkg::verdict_t slot_r [lcc_pkg::QDEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != CW'(lcc_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lcc_back.sv */
`default_nettype none
module lcc_back #(
  parameter int COUNT_BITS = lcc_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire lcc_pkg::verdict_t q_data,
  output logic                   q_pop,
  lcc_out_if.source              out_bus
);

  localparam int CB = COUNT_BITS;
  localparam int DW = COUNT_BITS + 2;
  localparam int TW = DW + 1;
  localparam int QW = lcc_pkg::Q_W;
  localparam int SW = $clog2(QW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    SEL_PREC = 2'd0,
    SEL_REC  = 2'd1,
    SEL_F1   = 2'd2
  } ratio_sel_t;

  state_t     st_r, st_nxt;
  ratio_sel_t sel_r, sel_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CB-1:0] tp_r, fp_r, tn_r, fn_r;
  logic [CB-1:0] tp_nxt, fp_nxt, tn_nxt, fn_nxt;
  logic [CB-1:0] tp_b, fp_b, tn_b, fn_b;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] num, den;
  logic [TW-1:0] trial;
  logic          ge;
  logic [QW-1:0] ratio;
  logic          div_end;

  logic        out_valid_r, out_valid_nxt;
  logic        pred_r, match_r, sv_r;
  logic [15:0] tpo_r, fpo_r, tno_r, fno_r, prec_r, rec_r, f1_r;

  function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
    bump = (&c) ? c : c + 1'b1;
  endfunction

  assign q_pop = (st_r == ST_IDLE) && q_valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    tp_b = tp_r;
    fp_b = fp_r;
    tn_b = tn_r;
    fn_b = fn_r;
    case ({q_data.pred, q_data.label})
      2'b11:   tp_b = bump(tp_r);
      2'b10:   fp_b = bump(fp_r);
      2'b01:   fn_b = bump(fn_r);
      default: tn_b = bump(tn_r);
    endcase
  end

  always_comb begin
    case (sel_r)
      SEL_PREC: begin
        num = DW'(tp_r);
        den = DW'(tp_r) + DW'(fp_r);
      end
      SEL_REC: begin
        num = DW'(tp_r);
        den = DW'(tp_r) + DW'(fn_r);
      end
      SEL_F1: begin
        num = DW'({tp_r, 1'b0});
        den = DW'({tp_r, 1'b0}) + DW'(fp_r) + DW'(fn_r);
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  // restoring division of num * 2^15 by den, one quotient bit a cycle
  always_comb begin
    trial   = (step_r == '0) ? TW'(num) : {rem_r, 1'b0};
    ge      = (trial >= TW'(den));
    rem_nxt = ge ? DW'(trial - TW'(den)) : DW'(trial);
    q_nxt   = {q_r[QW-2:0], ge};
    ratio   = (den == '0) ? '0 : q_nxt;
    div_end = (step_r == SW'(QW - 1));
  end

  always_comb begin
    st_nxt        = st_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    tp_nxt        = tp_r;
    fp_nxt        = fp_r;
    tn_nxt        = tn_r;
    fn_nxt        = fn_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    case (st_r)
      ST_IDLE: begin
        if (q_pop) begin
          tp_nxt   = tp_b;
          fp_nxt   = fp_b;
          tn_nxt   = tn_b;
          fn_nxt   = fn_b;
          sel_nxt  = SEL_PREC;
          step_nxt = '0;
          if (q_data.last) begin
            st_nxt = ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (div_end) begin
          step_nxt = '0;
          case (sel_r)
            SEL_PREC: sel_nxt = SEL_REC;
            SEL_REC:  sel_nxt = SEL_F1;
            default: begin
              tp_nxt        = '0;
              fp_nxt        = '0;
              tn_nxt        = '0;
              fn_nxt        = '0;
              out_valid_nxt = 1'b1;
              st_nxt        = ST_IDLE;
            end
          endcase
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sel_r       <= SEL_PREC;
      step_r      <= '0;
      tp_r        <= '0;
      fp_r        <= '0;
      tn_r        <= '0;
      fn_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sel_r       <= sel_nxt;
      step_r      <= step_nxt;
      tp_r        <= tp_nxt;
      fp_r        <= fp_nxt;
      tn_r        <= tn_nxt;
      fn_r        <= fn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pred_r  <= q_data.pred;
      match_r <= (q_data.pred == q_data.label);
      sv_r    <= q_data.last;
      tpo_r   <= 16'(tp_b);
      fpo_r   <= 16'(fp_b);
      tno_r   <= 16'(tn_b);
      fno_r   <= 16'(fn_b);
      prec_r  <= '0;
      rec_r   <= '0;
      f1_r    <= '0;
    end
    if (st_r == ST_DIV) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (div_end) begin
        case (sel_r)
          SEL_PREC: prec_r <= 16'(ratio);
          SEL_REC:  rec_r  <= 16'(ratio);
          default:  f1_r   <= 16'(ratio);
        endcase
      end
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.predicted     = pred_r;
  assign out_bus.matches_label = match_r;
  assign out_bus.true_pos      = tpo_r;
  assign out_bus.false_pos     = fpo_r;
  assign out_bus.true_neg      = tno_r;
  assign out_bus.false_neg     = fno_r;
  assign out_bus.precision_q   = prec_r;
  assign out_bus.recall_q      = rec_r;
  assign out_bus.f1_q          = f1_r;
  assign out_bus.summary_valid = sv_r;

endmodule
`default_nettype wire

/* rtl/core/logistic_classifier_confusion_scorer.sv */
// Logistic classifier scorer with confusion counters. Samples enter on
// in_bus; each gives one result beat on out_bus. The front registers the
// four 16x16 lane products and decides the sample in the next cycle, then
// hands the verdict to a two-entry queue; the back updates the saturating
// TP/FP/TN/FN counters and fills an output register. Samples pass product
// register, queue slot and output register in turn, new ones entering as
// old ones move on. A sample marked last holds the back while precision,
// recall and F1 come one after another from one restoring divider at one
// quotient bit a cycle; the front keeps taking samples until queue and front fill.
// Registers sit on an APB port at byte addresses 0 to 20 (weights a to d, bias,
// threshold); they are to be written only while the block is idle, which the block does not enforce.
`default_nettype none
module logistic_classifier_confusion_scorer #(
  parameter int NUM_FEATURES = lcc_pkg::NUM_FEATURES_DEF,
  parameter int COUNT_BITS   = lcc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lcc_in_if.sink                          in_bus,
  lcc_out_if.source                       out_bus,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lcc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [lcc_pkg::CFG_DW-1:0] pwdata,
  output logic      [lcc_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  lcc_pkg::cfg_t     cfg_r;
  lcc_pkg::verdict_t push_data, pop_data;
  logic push, q_ready, pop, pop_valid;
  logic wr_en;
  logic [lcc_pkg::IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[lcc_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        lcc_pkg::REG_WEIGHT_A: cfg_r.weight[0] <= pwdata[lcc_pkg::FEAT_W-1:0];
        lcc_pkg::REG_WEIGHT_B: cfg_r.weight[1] <= pwdata[lcc_pkg::FEAT_W-1:0];
        lcc_pkg::REG_WEIGHT_C: cfg_r.weight[2] <= pwdata[lcc_pkg::FEAT_W-1:0];
        lcc_pkg::REG_WEIGHT_D: cfg_r.weight[3] <= pwdata[lcc_pkg::FEAT_W-1:0];
        lcc_pkg::REG_BIAS:     cfg_r.bias      <= pwdata;
        lcc_pkg::REG_THRESH:   cfg_r.thresh    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lcc_pkg::REG_WEIGHT_A: prdata = lcc_pkg::CFG_DW'(cfg_r.weight[0]);
      lcc_pkg::REG_WEIGHT_B: prdata = lcc_pkg::CFG_DW'(cfg_r.weight[1]);
      lcc_pkg::REG_WEIGHT_C: prdata = lcc_pkg::CFG_DW'(cfg_r.weight[2]);
      lcc_pkg::REG_WEIGHT_D: prdata = lcc_pkg::CFG_DW'(cfg_r.weight[3]);
      lcc_pkg::REG_BIAS:     prdata = cfg_r.bias;
      lcc_pkg::REG_THRESH:   prdata = cfg_r.thresh;
      default:               prdata = '0;
    endcase
  end

  lcc_front #(
    .NUM_FEATURES(NUM_FEATURES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg       (cfg_r),
    .push_data (push_data),
    .push      (push),
    .q_ready   (q_ready)
  );

  lcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  lcc_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire

/* tb/scorer_checker.sv */
`default_nettype none
module scorer_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lcc_in_if                               in_mon,
  lcc_out_if                              out_mon,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [lcc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [lcc_pkg::CFG_DW-1:0] pwdata,
  output int                              fail_count,
  output int                              owed,
  output int                              samples_seen,
  output int                              beats_checked,
  output int                              summaries_seen
);
  import lcc_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic        predicted;
    logic        matches_label;
    logic [15:0] true_pos;
    logic [15:0] false_pos;
    logic [15:0] true_neg;
    logic [15:0] false_neg;
    logic [15:0] precision_q;
    logic [15:0] recall_q;
    logic [15:0] f1_q;
    logic        summary_valid;
  } tally_t;

  logic signed [FEAT_W-1:0] weight [LANES];
  logic signed [CFG_DW-1:0] bias;
  logic signed [CFG_DW-1:0] thresh;
  logic [15:0]              tp, fp, tn, fn;
  tally_t                   expected_tallies [$];

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic logic [15:0] q15_ratio(input longint unsigned num,
                                            input longint unsigned den);
    longint unsigned r;
    if (den == 0) return 16'd0;
    r = (num * 64'd32768) / den;
    if (r > 64'd32768) r = 64'd32768;
    return r[15:0];
  endfunction

  function automatic tally_t classify_and_tally(input logic signed [15:0] f0,
                                                input logic signed [15:0] f1,
                                                input logic signed [15:0] f2,
                                                input logic signed [15:0] f3,
                                                input logic label,
                                                input logic last);
    tally_t          t;
    longint          score;
    logic            pred;
    longint unsigned ntp, nfp, nfn;
    score = longint'(bias)
          + longint'(f0) * longint'(weight[0])
          + longint'(f1) * longint'(weight[1])
          + longint'(f2) * longint'(weight[2])
          + longint'(f3) * longint'(weight[3]);
    pred = (score >= longint'(thresh));
    if (pred) begin
      if (label) tp = sat_inc(tp);
      else       fp = sat_inc(fp);
    end else begin
      if (label) fn = sat_inc(fn);
      else       tn = sat_inc(tn);
    end
    t = '0;
    t.predicted     = pred;
    t.matches_label = (pred == label);
    t.true_pos      = tp;
    t.false_pos     = fp;
    t.true_neg      = tn;
    t.false_neg     = fn;
    if (last) begin
      ntp = tp;
      nfp = fp;
      nfn = fn;
      t.precision_q   = q15_ratio(ntp, ntp + nfp);
      t.recall_q      = q15_ratio(ntp, ntp + nfn);
      t.f1_q          = q15_ratio(2 * ntp, 2 * ntp + nfp + nfn);
      t.summary_valid = 1'b1;
      tp = '0;
      fp = '0;
      tn = '0;
      fn = '0;
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (fail_count < PRINT_CAP)
      $display("result beat %0d: %s is %0h, predicted %0h", beats_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    tally_t got;
    tally_t want;
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) weight[i] = '0;
      bias   = '0;
      thresh = '0;
      tp = '0;
      fp = '0;
      tn = '0;
      fn = '0;
      expected_tallies.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.predicted     = out_mon.predicted;
        got.matches_label = out_mon.matches_label;
        got.true_pos      = out_mon.true_pos;
        got.false_pos     = out_mon.false_pos;
        got.true_neg      = out_mon.true_neg;
        got.false_neg     = out_mon.false_neg;
        got.precision_q   = out_mon.precision_q;
        got.recall_q      = out_mon.recall_q;
        got.f1_q          = out_mon.f1_q;
        got.summary_valid = out_mon.summary_valid;
        if (expected_tallies.size() == 0) begin
          report_mismatch("beat with no sample pending", 1, 0);
        end else begin
          want = expected_tallies.pop_front();
          if (got.predicted !== want.predicted)
            report_mismatch("predicted", got.predicted, want.predicted);
          if (got.matches_label !== want.matches_label)
            report_mismatch("matches_label", got.matches_label, want.matches_label);
          if (got.true_pos !== want.true_pos)
            report_mismatch("true_pos", got.true_pos, want.true_pos);
          if (got.false_pos !== want.false_pos)
            report_mismatch("false_pos", got.false_pos, want.false_pos);
          if (got.true_neg !== want.true_neg)
            report_mismatch("true_neg", got.true_neg, want.true_neg);
          if (got.false_neg !== want.false_neg)
            report_mismatch("false_neg", got.false_neg, want.false_neg);
          if (got.precision_q !== want.precision_q)
            report_mismatch("precision_q", got.precision_q, want.precision_q);
          if (got.recall_q !== want.recall_q)
            report_mismatch("recall_q", got.recall_q, want.recall_q);
          if (got.f1_q !== want.f1_q)
            report_mismatch("f1_q", got.f1_q, want.f1_q);
          if (got.summary_valid !== want.summary_valid)
            report_mismatch("summary_valid", got.summary_valid, want.summary_valid);
        end
        beats_checked++;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        expected_tallies.push_back(classify_and_tally(in_mon.feature_a, in_mon.feature_b,
                                                      in_mon.feature_c, in_mon.feature_d,
                                                      in_mon.true_label,
                                                      in_mon.last_sample));
        samples_seen++;
        if (in_mon.last_sample) summaries_seen++;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_WEIGHT_A: weight[0] = pwdata[FEAT_W-1:0];
          REG_WEIGHT_B: weight[1] = pwdata[FEAT_W-1:0];
          REG_WEIGHT_C: weight[2] = pwdata[FEAT_W-1:0];
          REG_WEIGHT_D: weight[3] = pwdata[FEAT_W-1:0];
          REG_BIAS:     bias      = pwdata;
          REG_THRESH:   thresh    = pwdata;
          default: ;
        endcase
      end
    end
    owed <= expected_tallies.size();
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
  import lcc_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 85;
  localparam int RUN_PER_CLASS = 5;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic signed [15:0] fc;
    logic signed [15:0] fd;
    logic               label;
    logic               last;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int   fail_count, owed, samples_seen, beats_checked, summaries_seen;
  int   settings_used = 0;
  int   idle_cycles = 0;
  int   burst_left = 1;
  logic hold_req = 1'b0;
  logic rx_free = 1'b0;

  lcc_in_if  in_bus ();
  lcc_out_if out_bus ();

  logistic_classifier_confusion_scorer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scorer_checker tally_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .owed           (owed),
    .samples_seen   (samples_seen),
    .beats_checked  (beats_checked),
    .summaries_seen (summaries_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("logistic_classifier_confusion_scorer: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: own stall pattern, long hold-off on request, free-running on request
  initial begin : receiver
    int run_len;
    int stall_len;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_free) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        out_bus.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (stall_len > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  function automatic sample_t mk(input logic [15:0] fa, input logic [15:0] fb,
                                 input logic [15:0] fc, input logic [15:0] fd,
                                 input logic label, input logic last);
    sample_t s;
    s.fa    = fa;
    s.fb    = fb;
    s.fc    = fc;
    s.fd    = fd;
    s.label = label;
    s.last  = last;
    return s;
  endfunction

  function automatic logic [15:0] pick_lane();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h1000;
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return {{4{r[27]}}, r[27:0]};
      default: return r;
    endcase
  endfunction

  function automatic sample_t random_sample();
    return mk(pick_lane(), pick_lane(), pick_lane(), pick_lane(),
              1'($urandom_range(0, 1)), ($urandom_range(0, 11) == 0));
  endfunction

  task automatic offer_sample(input sample_t s);
    in_bus.valid       <= 1'b1;
    in_bus.feature_a   <= s.fa;
    in_bus.feature_b   <= s.fb;
    in_bus.feature_c   <= s.fc;
    in_bus.feature_d   <= s.fd;
    in_bus.true_label  <= s.label;
    in_bus.last_sample <= s.last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3,
                             input logic [31:0] b, input logic [31:0] t);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_WEIGHT_A, {junk, w0});
    write_reg(REG_WEIGHT_B, {~junk, w1});
    write_reg(REG_WEIGHT_C, {junk, w2});
    write_reg(REG_WEIGHT_D, {~junk, w3});
    write_reg(REG_BIAS, b);
    write_reg(REG_THRESH, t);
    settings_used++;
  endtask

  initial begin : stimulus
    sample_t s;
    int      n;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.feature_a   = '0;
    in_bus.feature_b   = '0;
    in_bus.feature_c   = '0;
    in_bus.feature_d   = '0;
    in_bus.true_label  = 1'b0;
    in_bus.last_sample = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: score 0 meets threshold 0; a set with an empty recall, then a full-scale set
    offer_sample(mk(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
    pace();
    offer_sample(mk(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1));
    pace();
    offer_sample(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
    drain();

    load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000);
    offer_sample(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0));
    pace();
    offer_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
    pace();
    offer_sample(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
    pace();
    offer_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1));
    drain();

    // top of range; spare addresses must not disturb anything
    load_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(REG_SPARE_A, 32'hDEAD_BEEF);
    write_reg(REG_SPARE_B, 32'h8000_0001);
    offer_sample(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
    pace();
    offer_sample(mk(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
    pace();
    offer_sample(mk(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
    pace();
    offer_sample(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      load_config(pick_lane(), pick_lane(), pick_lane(), pick_lane(),
                  pick_word(), pick_word());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 10) hold_req = 1'b1;
        offer_sample(random_sample());
        if (!(p == 1 && i >= 10 && i < 50)) pace();
        if (p == 3 && i == 40) drain();
      end
      drain();
    end

    // back-to-back beats with the receiver always ready, one class per beat in turn
    rx_free = 1'b1;
    load_config(16'h1000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0);
    n = 4 * RUN_PER_CLASS;
    for (int i = 0; i < n; i++) begin
      s = random_sample();
      s.fa    = (i % 4 < 2) ? 16'sh0001 : 16'shFFFF;
      s.label = (i % 4 == 0) || (i % 4 == 3);
      s.last  = (i == n - 1);
      offer_sample(s);
    end
    drain();
    rx_free = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples scored under %0d register settings, %0d sets closed with ratios",
             samples_seen, settings_used, summaries_seen);
    $display("extremes, ties at the threshold, empty ratios, a long output hold-off and %s",
             "a free-running run through all four classes were exercised");
    if (fail_count == 0 && owed == 0) begin
      $display("logistic_classifier_confusion_scorer: match");
    end else begin
      $display("logistic_classifier_confusion_scorer: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
